[rtl/lmb_pkg.sv]
package lmb_pkg;

    localparam int unsigned LOG_TABLE_ENTRIES_DEF = 64;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RISE_COEFF       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_COEFF       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FALL_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HOLD_FRAMES = 3'd5;

    localparam logic [15:0] RISE_COEFF_RST       = 16'd32768;
    localparam logic [15:0] FALL_COEFF_RST       = 16'd3277;
    localparam logic [6:0]  SEGMENT_COUNT_RST    = 7'd16;
    localparam logic [15:0] PEAK_HOLD_FRAMES_RST = 16'd30;
    localparam logic [15:0] PEAK_FALL_STEP_RST   = 16'd328;
    localparam logic [15:0] CLIP_HOLD_FRAMES_RST = 16'd60;

    localparam logic [15:0] FULL_SCALE    = 16'd32768;
    localparam logic [16:0] DB_SCALE_Q20  = 17'd105218;
    localparam logic [15:0] SNAP_LSB      = 16'd17;
    localparam logic [15:0] CLIP_LEVEL    = 16'd30802;
    localparam logic [22:0] SILENCE_LIMIT = 23'd16384;

    typedef struct packed {
        logic load;
        logic log_en;
        logic rom_en;
        logic mul_en;
        logic bar_en;
        logic upd_en;
        logic sil_en;
        logic draw_en;
    } lmb_cmd_t;

    function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // log2(1 + i/n) in q16, evaluated at elaboration only
    function automatic logic [15:0] log_frac_entry(input int unsigned i, input int unsigned n);
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] y;
        logic [15:0] r;
        num = (64'(n) + 64'(i)) << 30;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[62:0], num[k]};
            if (rem >= 64'(n))
            begin
                rem    = rem - 64'(n);
                quo[k] = 1'b1;
            end
        end
        y = quo;
        r = '0;
        for (int b = 0; b < 16; b++)
        begin
            y = (y * y) >> 30;
            r = {r[14:0], 1'b0};
            if (y >= 64'h0000_0000_8000_0000)
            begin
                r[0] = 1'b1;
                y    = y >> 1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/lmb_ctrl.sv]
module lmb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output lmb_pkg::lmb_cmd_t cmd
);
    import lmb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOG,
        S_ROM,
        S_MUL,
        S_BAR,
        S_UPD,
        S_SIL,
        S_DRAW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == S_IDLE) && in_valid;
        cmd.log_en  = (state_reg == S_LOG);
        cmd.rom_en  = (state_reg == S_ROM);
        cmd.mul_en  = (state_reg == S_MUL);
        cmd.bar_en  = (state_reg == S_BAR);
        cmd.upd_en  = (state_reg == S_UPD);
        cmd.sil_en  = (state_reg == S_SIL);
        cmd.draw_en = (state_reg == S_DRAW) && slot_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOG;
            end
            S_LOG:  state_next = S_ROM;
            S_ROM:  state_next = S_MUL;
            S_MUL:  state_next = S_BAR;
            S_BAR:  state_next = S_UPD;
            S_UPD:  state_next = S_SIL;
            S_SIL:  state_next = S_DRAW;
            S_DRAW:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_to_draw: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> ##7 (state_reg == S_DRAW))
        else $error("item did not reach draw stage in time");

    a_rose_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DRAW))
        else $error("result shown without a draw step");

    a_draw_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW && out_valid_reg && out_stall) |=> (state_reg == S_DRAW))
        else $error("draw step left while output slot was busy");

endmodule

[rtl/lmb_datapath.sv]
module lmb_datapath #(
    parameter int unsigned LOG_TABLE_ENTRIES = lmb_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lmb_pkg::lmb_cmd_t               cmd,
    input  logic                            cfg_write,
    input  logic [lmb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [15:0]                     linear_level,
    output logic [15:0]                     bar_level,
    output logic [15:0]                     peak_level,
    output logic                            clip_lit,
    output logic                            redraw
);
    import lmb_pkg::*;

    localparam int unsigned IDX_W = $clog2(LOG_TABLE_ENTRIES);
    localparam int unsigned NW    = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int unsigned PW    = 15 + NW;

    logic [15:0] log_rom [LOG_TABLE_ENTRIES];

    for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++)
    begin : g_rom
        assign log_rom[g] = log_frac_entry(g, LOG_TABLE_ENTRIES);
    end

    // configuration
    logic [15:0] rise_coeff_reg;
    logic [15:0] fall_coeff_reg;
    logic [6:0]  segment_count_reg;
    logic [15:0] peak_hold_frames_reg;
    logic [15:0] peak_fall_step_reg;
    logic [15:0] clip_hold_frames_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_coeff_reg       <= RISE_COEFF_RST;
            fall_coeff_reg       <= FALL_COEFF_RST;
            segment_count_reg    <= SEGMENT_COUNT_RST;
            peak_hold_frames_reg <= PEAK_HOLD_FRAMES_RST;
            peak_fall_step_reg   <= PEAK_FALL_STEP_RST;
            clip_hold_frames_reg <= CLIP_HOLD_FRAMES_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RISE_COEFF:       rise_coeff_reg       <= cfg_data;
                REG_FALL_COEFF:       fall_coeff_reg       <= cfg_data;
                REG_SEGMENT_COUNT:    segment_count_reg    <= cfg_data[6:0];
                REG_PEAK_HOLD_FRAMES: peak_hold_frames_reg <= cfg_data;
                REG_PEAK_FALL_STEP:   peak_fall_step_reg   <= cfg_data;
                REG_CLIP_HOLD_FRAMES: clip_hold_frames_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [6:0] seg;
    assign seg = (segment_count_reg == '0) ? 7'd1 : segment_count_reg;

    // normalisation pipeline
    logic [15:0]      x_reg;
    logic             zero_reg;
    logic             full_reg;
    logic [3:0]       shift_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      rom_reg;
    logic [15:0]      target_reg;

    logic [3:0]  lead_pos;
    logic [3:0]  shift_next;
    logic [15:0] xn;
    logic [PW-1:0] frac_prod;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        lead_pos = '0;
        for (int b = 0; b < 15; b++)
        begin
            if (x_reg[b])
                lead_pos = 4'(b);
        end
        shift_next = 4'd15 - lead_pos;
        xn         = x_reg << shift_next;
        frac_prod  = PW'(xn[14:0]) * PW'(LOG_TABLE_ENTRIES);
        idx_next   = IDX_W'(frac_prod[PW-1:15]);
    end

    logic [19:0] neg_log;
    logic [36:0] drop_prod;
    logic [15:0] drop;
    logic [15:0] target_next;

    always_comb
    begin
        neg_log   = {shift_reg, 16'h0000} - {4'h0, rom_reg};
        drop_prod = 37'(neg_log) * 37'(DB_SCALE_Q20);
        drop      = drop_prod[36:21];
        if (zero_reg)
            target_next = '0;
        else if (full_reg)
            target_next = FULL_SCALE;
        else if (drop >= FULL_SCALE)
            target_next = '0;
        else
            target_next = FULL_SCALE - drop;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= linear_level;
        if (cmd.log_en)
        begin
            zero_reg  <= (x_reg == '0);
            full_reg  <= x_reg[15];
            shift_reg <= shift_next;
            idx_reg   <= idx_next;
        end
        if (cmd.rom_en)
            rom_reg <= log_rom[idx_reg];
        if (cmd.mul_en)
            target_reg <= target_next;
    end

    // ballistics state
    logic [15:0] bar_reg;
    logic [15:0] peak_reg;
    logic [15:0] peak_hold_reg;
    logic [15:0] clip_hold_reg;
    logic        fall_reg;
    logic [15:0] shown_bar_reg;
    logic [15:0] shown_peak_reg;
    logic        shown_clip_reg;
    logic [15:0] step_reg;
    logic        rising_reg;

    logic        rising;
    logic [15:0] coeff;
    logic [31:0] step_prod;

    always_comb
    begin
        rising    = target_reg > bar_reg;
        coeff     = rising ? rise_coeff_reg : fall_coeff_reg;
        if (coeff > FULL_SCALE)
            coeff = FULL_SCALE;
        step_prod = 32'(abs_diff(target_reg, bar_reg)) * 32'(coeff);
    end

    logic [15:0] bar_moved;
    logic [15:0] bar_next;
    logic [15:0] peak_next;
    logic [15:0] peak_hold_next;
    logic [15:0] clip_hold_next;
    logic        fall_next;
    logic [15:0] fallen;

    always_comb
    begin
        bar_moved = rising_reg ? (bar_reg + step_reg) : (bar_reg - step_reg);
        bar_next  = (abs_diff(target_reg, bar_moved) < SNAP_LSB) ? target_reg : bar_moved;

        fallen         = (peak_reg > peak_fall_step_reg) ? (peak_reg - peak_fall_step_reg) : '0;
        peak_next      = peak_reg;
        peak_hold_next = peak_hold_reg;
        fall_next      = 1'b0;
        if (target_reg >= peak_reg)
        begin
            peak_next      = target_reg;
            peak_hold_next = peak_hold_frames_reg;
        end
        else if (peak_hold_reg != '0)
            peak_hold_next = peak_hold_reg - 16'd1;
        else
        begin
            peak_next = (fallen > target_reg) ? fallen : target_reg;
            fall_next = 1'b1;
        end

        if (target_reg >= CLIP_LEVEL)
            clip_hold_next = clip_hold_frames_reg;
        else if (clip_hold_reg != '0)
            clip_hold_next = clip_hold_reg - 16'd1;
        else
            clip_hold_next = clip_hold_reg;
    end

    logic [22:0] bar_seg;
    logic [22:0] peak_seg;
    logic [22:0] bar_dist;
    logic [22:0] peak_dist;
    logic        lit;
    logic        moved;

    always_comb
    begin
        bar_seg   = 23'(bar_reg) * 23'(seg);
        peak_seg  = 23'(peak_reg) * 23'(seg);
        bar_dist  = 23'(abs_diff(bar_reg, shown_bar_reg)) * 23'(seg);
        peak_dist = 23'(abs_diff(peak_reg, shown_peak_reg)) * 23'(seg);
        lit       = (clip_hold_reg != '0);
        // distance times four reaches full scale
        moved     = (bar_dist[22:13] != '0) || (peak_dist[22:13] != '0)
                    || (lit != shown_clip_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_reg        <= '0;
            peak_reg       <= '0;
            peak_hold_reg  <= '0;
            clip_hold_reg  <= '0;
            fall_reg       <= 1'b0;
            shown_bar_reg  <= '0;
            shown_peak_reg <= '0;
            shown_clip_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_en)
            begin
                bar_reg       <= bar_next;
                peak_reg      <= peak_next;
                peak_hold_reg <= peak_hold_next;
                clip_hold_reg <= clip_hold_next;
                fall_reg      <= fall_next;
            end
            if (cmd.sil_en)
            begin
                if (target_reg == '0 && bar_seg < SILENCE_LIMIT)
                    bar_reg <= '0;
                if (fall_reg && target_reg == '0 && peak_seg < SILENCE_LIMIT)
                    peak_reg <= '0;
            end
            if (cmd.draw_en && moved)
            begin
                shown_bar_reg  <= bar_reg;
                shown_peak_reg <= peak_reg;
                shown_clip_reg <= lit;
            end
        end
    end

    logic [15:0] bar_level_reg;
    logic [15:0] peak_level_reg;
    logic        clip_lit_reg;
    logic        redraw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.bar_en)
        begin
            step_reg   <= step_prod[30:15];
            rising_reg <= rising;
        end
        if (cmd.draw_en)
        begin
            bar_level_reg  <= bar_reg;
            peak_level_reg <= peak_reg;
            clip_lit_reg   <= lit;
            redraw_reg     <= moved;
        end
    end

    assign bar_level  = bar_level_reg;
    assign peak_level = peak_level_reg;
    assign clip_lit   = clip_lit_reg;
    assign redraw     = redraw_reg;

    a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
        bar_reg <= FULL_SCALE)
        else $error("bar above full scale");

    a_peak_covers_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sil_en |-> (peak_reg >= target_reg))
        else $error("peak below current target after update");

    a_silence_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sil_en && target_reg == '0 && bar_seg < SILENCE_LIMIT) |=> (bar_reg == '0))
        else $error("bar not snapped to silence");

endmodule

[rtl/level_meter_ballistics_core.sv]
// level meter with bar ballistics, peak hold and clip lamp
// input channel: in_valid / in_stall carry one linear level per beat
// output channel: out_valid / out_stall carry bar, peak, clip lamp and
// redraw flag, one result beat for every input beat
// configuration: cfg_write with cfg_index and cfg_data, written while idle by
// the user (not enforced by the block); after an input beat is accepted one
// shared sequencer walks log, table read, scale, bar step, update, silence
// and redraw stages, loading the result register in the redraw stage; the
// next item is taken once the sequencer is back in idle, not before
// the result sits in an output register, so a new item is taken while the
// previous result is still waiting; a stalled result holds the sequencer
// in its last stage until the output register frees
// reset clears all meter state to silence and loads default register values
module level_meter_ballistics_core #(
    parameter int unsigned LOG_TABLE_ENTRIES = lmb_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     linear_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     bar_level,
    output logic [15:0]                     peak_level,
    output logic                            clip_lit,
    output logic                            redraw,
    input  logic                            cfg_write,
    input  logic [lmb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lmb_pkg::*;

    lmb_cmd_t cmd;

    lmb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lmb_datapath #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .linear_level (linear_level),
        .bar_level    (bar_level),
        .peak_level   (peak_level),
        .clip_lit     (clip_lit),
        .redraw       (redraw)
    );

endmodule
